FILE: rtl/stbs_pkg.sv
// shared types, constants and state codes of the sorted table search core
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int CFG_W           = 11;
  localparam int IDX_W           = 10;
  localparam int VAL_W           = 32;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(1024);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [IDX_W-1:0]        load_index;
    logic signed [VAL_W-1:0] load_value;
    logic signed [VAL_W-1:0] search_key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PROBE
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic issue;
    logic step;
    logic done_hit;
    logic done_miss;
  } dp_cmd_t;

  typedef struct packed {
    logic cur_empty;
    logic hit;
    logic nxt_empty;
  } dp_status_t;

endpackage

FILE: rtl/stbs_ctrl.sv
// search controller: issues loads and sequences setup and probe steps of the datapath
module stbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 mode,
  input  stbs_pkg::dp_status_t status,
  output stbs_pkg::dp_cmd_t    cmd,
  output logic                 busy
);
  import stbs_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (mode == MODE_SEARCH) begin
            cmd.init  = 1'b1;
            state_nxt = ST_SETUP;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        if (status.cur_empty) begin
          cmd.done_miss = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (status.hit) begin
          cmd.done_hit = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (status.nxt_empty) begin
          cmd.step      = 1'b1;
          cmd.done_miss = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/stbs_datapath.sv
// table memory, range registers, probe compare and result register
module stbs_datapath #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stbs_pkg::dp_cmd_t                 cmd,
  input  stbs_pkg::in_item_t                in_item,
  input  logic                              cfg_we,
  input  logic [stbs_pkg::CFG_W-1:0]        cfg_entries_in_use,
  output stbs_pkg::dp_status_t              status,
  output logic                              out_valid,
  output stbs_pkg::out_item_t               out_item
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [VAL_W-1:0] mem [TABLE_DEPTH];

  logic [CFG_W-1:0]        entries_r;
  logic [CW-1:0]           low_r, hi_r;
  logic [AW-1:0]           mid_r;
  logic signed [VAL_W-1:0] key_r, rd_r;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  logic [CW-1:0]           n_clamp;
  logic [CW-1:0]           span_cur, mid_cur_w, span_nxt, mid_nxt_w;
  logic [CW-1:0]           nxt_low, nxt_hi;
  logic [AW-1:0]           rd_addr;
  logic                    go_lower, load_ok;

  // live range is [low, hi) with the upper bound exclusive
  assign n_clamp = (32'(entries_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entries_r);

  assign span_cur  = hi_r - low_r - CW'(1);
  assign mid_cur_w = low_r + (span_cur >> 1);

  assign go_lower = (rd_r > key_r);
  assign nxt_low  = go_lower ? low_r : (CW'(mid_r) + CW'(1));
  assign nxt_hi   = go_lower ? CW'(mid_r) : hi_r;
  assign span_nxt  = nxt_hi - nxt_low - CW'(1);
  assign mid_nxt_w = nxt_low + (span_nxt >> 1);

  assign rd_addr = cmd.issue ? mid_cur_w[AW-1:0] : mid_nxt_w[AW-1:0];
  assign load_ok = (32'(in_item.load_index) < 32'(TABLE_DEPTH));

  assign status.cur_empty = (low_r >= hi_r);
  assign status.hit       = (rd_r == key_r);
  assign status.nxt_empty = (nxt_low >= nxt_hi);

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[AW'(in_item.load_index)] <= in_item.load_value;
    end
    if (cmd.issue || cmd.step) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      low_r <= '0;
      hi_r  <= n_clamp;
      key_r <= in_item.search_key;
    end else if (cmd.step) begin
      low_r <= nxt_low;
      hi_r  <= nxt_hi;
    end
    if (cmd.issue || cmd.step) begin
      mid_r <= rd_addr;
    end
    if (cmd.done_hit) begin
      out_item_r.found    <= 1'b1;
      out_item_r.position <= IDX_W'(mid_r);
    end else if (cmd.done_miss) begin
      out_item_r.found    <= 1'b0;
      out_item_r.position <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= ENTRIES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_r <= cfg_entries_in_use;
      end
      out_valid_r <= cmd.done_hit || cmd.done_miss;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/sorted_table_binary_search_core.sv
// top level of the sorted table binary search core
//
// items enter on in_item and are taken at a clock edge with start high and
// busy low. a load item (mode 0) writes one table entry at that edge, gives
// no result and leaves busy low, so loads go at one per cycle.
// a search item (mode 1) raises busy for a setup step and then p probes, where
// p is the number of probes; each probe is one read of the table memory, so p
// is at most log2(depth) + 1, 11 for a table of 1024 entries.
// the result shows on out_item for exactly one cycle with out_valid high,
// in the first cycle in which busy is low again.
// the receiver cannot stall; a result not taken in its cycle is gone.
// the entries_in_use register is written through cfg_valid / cfg_ready;
// cfg_ready is high whenever busy is low.
// synchronous reset clears the controller, the result strobe and sets
// entries_in_use to 1024; table contents are undefined until loaded.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  stbs_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output stbs_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [stbs_pkg::CFG_W-1:0] cfg_entries_in_use
);
  import stbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy_w;

  stbs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .mode   (in_item.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy_w)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_item            (in_item),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use),
    .status             (status),
    .out_valid          (out_valid),
    .out_item           (out_item)
  );

  assign busy      = busy_w;
  assign cfg_ready = !busy_w;

endmodule

FILE: rtl/stbs_checker.sv
// port-level checker for the search core, bound to the top level
module stbs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input stbs_pkg::in_item_t  in_item,
  input logic                out_valid,
  input stbs_pkg::out_item_t out_item
);
  import stbs_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> (!busy && !out_valid))
    else $error("core not idle after reset");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == MODE_LOAD) |=> (!busy && !out_valid))
    else $error("load item made the core busy or gave a result");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.mode == MODE_SEARCH) |=> (busy && !out_valid))
    else $error("search item did not start");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |-> (out_item.position == '0))
    else $error("position not zero on a miss");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

FILE: test/tb_top.sv
// self-checking testbench of the sorted table binary search core: loads, searches, register writes
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int DEPTH         = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic signed [VAL_W-1:0] KEY_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] KEY_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_entries_in_use;

  sorted_table_binary_search_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_item            (in_item),
    .out_valid          (out_valid),
    .out_item           (out_item),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  // predictor state, updated at accepted items
  logic signed [VAL_W-1:0] table_model [DEPTH];
  logic [CFG_W-1:0]        entries_model;
  out_item_t               expected_lookups [$];
  out_item_t               oldest_lookup;

  // stimulus side view of the table, kept in item order
  logic signed [VAL_W-1:0] planned_table [DEPTH];
  int                      planned_entries;

  in_item_t item_queue [$];
  int       idle_pct;
  int       errors;
  int       cycle_count;
  logic     taken_q;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t binary_lookup(input logic signed [VAL_W-1:0] key);
    int        lo;
    int        hi;
    int        mid;
    int        span;
    out_item_t res;
    res  = '0;
    span = (entries_model > DEPTH) ? DEPTH : int'(entries_model);
    lo   = 0;
    hi   = span - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_model[mid] == key) begin
        res.found    = 1'b1;
        res.position = IDX_W'(mid);
        break;
      end else if (table_model[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  // monitor and predictor
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      cycle_count++;
      taken_q <= rst_n && start && !busy;
      if (!rst_n) begin
        entries_model = ENTRIES_RESET;
      end else begin
        if (out_valid) begin
          if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("result found=%0b position=%0d with none expected",
                                      out_item.found, out_item.position));
          end else begin
            oldest_lookup = expected_lookups.pop_front();
            if (out_item.found !== oldest_lookup.found)
              report_mismatch($sformatf("found %0b, expected %0b",
                                        out_item.found, oldest_lookup.found));
            if (out_item.position !== oldest_lookup.position)
              report_mismatch($sformatf("position %0d, expected %0d",
                                        out_item.position, oldest_lookup.position));
          end
        end
        if (start && !busy) begin
          if (in_item.mode == MODE_LOAD)
            table_model[in_item.load_index] = in_item.load_value;
          else
            expected_lookups.push_back(binary_lookup(in_item.search_key));
        end
        if (cfg_valid && cfg_ready)
          entries_model = cfg_entries_in_use;
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken_q) begin
      if (item_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_item <= item_queue.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_load(input int idx, input logic signed [VAL_W-1:0] v);
    in_item_t it;
    it.mode       = MODE_LOAD;
    it.load_index = IDX_W'(idx);
    it.load_value = v;
    it.search_key = $urandom();
    planned_table[idx] = v;
    item_queue.push_back(it);
  endtask

  task automatic push_search(input logic signed [VAL_W-1:0] key);
    in_item_t it;
    it.mode       = MODE_SEARCH;
    it.load_index = IDX_W'($urandom_range(DEPTH - 1));
    it.load_value = $urandom();
    it.search_key = key;
    item_queue.push_back(it);
  endtask

  // a value that keeps the table ascending around idx
  function automatic logic signed [VAL_W-1:0] value_between(input int idx);
    longint lo;
    longint hi;
    longint span;
    lo = (idx == 0) ? longint'(KEY_MIN) : longint'(planned_table[idx-1]);
    hi = (idx == DEPTH - 1) ? longint'(KEY_MAX) : longint'(planned_table[idx+1]);
    if (hi < lo)
      return VAL_W'(lo);
    span = hi - lo + 1;
    return VAL_W'(lo + longint'({$urandom(), $urandom()} % span));
  endfunction

  task automatic push_random_search();
    int                      r;
    int                      live;
    int                      idx;
    logic signed [VAL_W-1:0] key;
    live = (planned_entries > DEPTH) ? DEPTH : planned_entries;
    r    = $urandom_range(99);
    idx  = (live > 0) ? $urandom_range(live - 1) : 0;
    if (r < 55)
      key = planned_table[idx];
    else if (r < 62)
      key = planned_table[$urandom_range(DEPTH - 1)];
    else if (r < 75)
      key = $urandom_range(1) ? planned_table[idx] + 1 : planned_table[idx] - 1;
    else if (r < 78)
      key = $urandom_range(1) ? KEY_MAX : KEY_MIN;
    else
      key = $urandom();
    push_search(key);
  endtask

  task automatic push_random_items(input int count);
    int r;
    int idx;
    repeat (count) begin
      r   = $urandom_range(99);
      idx = $urandom_range(DEPTH - 1);
      if (r < 70)
        push_random_search();
      else if (r < 97)
        push_load(idx, value_between(idx));
      else
        push_load(idx, $urandom());
    end
  endtask

  task automatic wait_idle();
    while (item_queue.size() != 0 || start || expected_lookups.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entries(input int n);
    @(negedge clk);
    cfg_valid          <= 1'b1;
    cfg_entries_in_use <= CFG_W'(n);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid          <= 1'b0;
    planned_entries = n;
  endtask

  task automatic run_phase(input int n, input int idle, input int count);
    write_entries(n);
    idle_pct = idle;
    push_random_items(count);
    wait_idle();
  endtask

  initial begin
    longint lv;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_item            = '0;
    cfg_valid          = 1'b0;
    cfg_entries_in_use = '0;
    idle_pct           = 0;
    errors             = 0;
    cycle_count        = 0;
    taken_q            = 1'b0;
    planned_entries    = DEPTH;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole table in ascending order, with a few runs of equal values
    for (int i = 0; i < DEPTH; i++) begin
      lv = longint'(KEY_MIN) + longint'(i) * 64'sd4194304 + longint'($urandom_range(4194303));
      if (i == 0)
        lv = longint'(KEY_MIN);
      if (i == DEPTH - 1)
        lv = longint'(KEY_MAX);
      if (i == 301 || i == 701 || i == 702)
        lv = longint'(planned_table[i-1]);
      push_load(i, VAL_W'(lv));
    end
    wait_idle();

    // directed items at the reset setting of the register
    push_search(KEY_MIN);
    push_search(KEY_MAX);
    push_search(planned_table[511]);
    push_search(planned_table[300]);
    push_search(planned_table[702]);
    push_search(planned_table[40] + 1);
    wait_idle();

    // empty range
    write_entries(0);
    push_search(KEY_MIN);
    push_search(planned_table[0]);
    wait_idle();

    // range wider than the table
    write_entries((1 << CFG_W) - 1);
    push_search(KEY_MAX);
    push_search(planned_table[1000]);
    push_search(planned_table[3] - 1);
    wait_idle();

    // single entry
    write_entries(1);
    push_search(planned_table[0]);
    push_search(planned_table[1]);
    wait_idle();

    // unsorted table, then order restored
    write_entries(DEPTH);
    push_load(512, KEY_MIN);
    push_search(KEY_MIN);
    push_search(planned_table[600]);
    push_load(512, value_between(512));
    push_search(planned_table[512]);
    wait_idle();

    run_phase(DEPTH, 0, 20);
    run_phase($urandom_range(2, DEPTH - 1), 87, 20);
    run_phase(1, 25, 12);
    run_phase((1 << CFG_W) - 1, 87, 20);

    // sender holds off mid phase until every result is in
    write_entries($urandom_range(2, DEPTH));
    idle_pct = 25;
    push_random_items(10);
    wait_idle();
    push_random_items(10);
    wait_idle();

    run_phase(DEPTH, 0, 18);

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sorted_table_binary_search_core.f
rtl/stbs_pkg.sv
rtl/stbs_ctrl.sv
rtl/stbs_datapath.sv
rtl/sorted_table_binary_search_core.sv
rtl/stbs_checker.sv
test/tb_top.sv
